/* rtl/i2cm_pkg.sv */
// i2cm_pkg: shared widths, reset values and the result word type of the
// bit-bang I2C master. Used by the channel interfaces and the engine.
package i2cm_pkg;

  localparam int PAYLOAD_DEPTH = 8;
  localparam int PL_AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  localparam int FUNC_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int BIDX_W   = 3;
  localparam int LEN_W    = 4;
  localparam int STATUS_W = 2;
  localparam int ATT_W    = 3;
  localparam int RCLK_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] WR_ADDR_RST = 8'h88;
  localparam logic [BYTE_W-1:0] RD_ADDR_RST = 8'h89;
  localparam logic [ATT_W-1:0]  MAX_ATT_RST = 3'd3;
  localparam logic [RCLK_W-1:0] REC_CLK_RST = 4'd10;

  typedef struct packed {
    logic                scl_level;
    logic                sda_release;
    logic [BYTE_W-1:0]   read_data;
    logic                read_valid;
    logic                read_last;
    logic                done_res;
    logic [STATUS_W-1:0] status;
    logic                busy_res;
  } i2cm_res_t;

endpackage

/* rtl/i2cm_if.sv */
// i2cm_if: valid/ready channel interfaces of the bit-bang I2C master
// (command input, result output, register write). Depends on i2cm_pkg.
interface i2cm_in_if;
  import i2cm_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic              sda_in;
  logic [BYTE_W-1:0] byte_value;
  logic [BIDX_W-1:0] byte_index;
  logic [LEN_W-1:0]  length;
  modport source(output valid, func, sda_in, byte_value, byte_index, length, input ready);
  modport sink(input valid, func, sda_in, byte_value, byte_index, length, output ready);
endinterface

interface i2cm_out_if;
  import i2cm_pkg::*;
  logic                valid;
  logic                ready;
  logic                scl_level;
  logic                sda_release;
  logic [BYTE_W-1:0]   read_data;
  logic                read_valid;
  logic                read_last;
  logic                done_res;
  logic [STATUS_W-1:0] status;
  logic                busy_res;
  modport source(output valid, scl_level, sda_release, read_data, read_valid, read_last,
                 done_res, status, busy_res, input ready);
  modport sink(input valid, scl_level, sda_release, read_data, read_valid, read_last,
               done_res, status, busy_res, output ready);
endinterface

interface i2cm_cfg_if;
  import i2cm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/i2c_master_bitbang_engine.sv */
// i2c_master_bitbang_engine: tick-driven I2C master, bus sequencer plus a
// two-entry result buffer. Depends on i2cm_pkg and the i2cm_*_if interfaces.
//
// Usage:
//   in_ch carries one command word per handshake: a tick (one bus delay
//   period, sda_in sampled on it), a payload byte load, a write start, a
//   read start or a bus recovery request. Commands other than ticks take
//   no bus time; pins only move on ticks.
//   out_ch returns exactly one word for each accepted input word: SCL level,
//   SDA drive, a received byte with valid/last flags, done, status and busy.
//   cfg_ch writes write_address (0), read_address (1), max_attempts (2) and
//   recovery_clocks (3); cfg_ch.ready is always high, write only while idle.
// Result path and throughput:
//   a word's result is registered in the output or skid register; one word
//   is accepted every cycle unless in_ch.ready is low. The sequencer step is
//   a single combinational pass between the state registers and the output register.
// Stall:
//   an output register plus a skid register hold up to two results, so a
//   word is still taken in the cycle the receiver first stalls; in_ch.ready
//   drops only while both are full.
// Reset (rst_n low, synchronous): sequencer idle, SCL high, SDA high,
//   registers back to 0x88/0x89/3/10, result buffer empty. Payload bytes
//   are not cleared.
module i2c_master_bitbang_engine (
  input  logic       clk,
  input  logic       rst_n,
  i2cm_in_if.sink    in_ch,
  i2cm_out_if.source out_ch,
  i2cm_cfg_if.sink   cfg_ch
);
  import i2cm_pkg::*;

  localparam logic [FUNC_W-1:0] FN_TICK  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_LOAD  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_WRITE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_READ  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REC   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_WR_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RD_ADDR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REC_CLK = 2'd3;

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_START  = 4'd1;
  localparam logic [3:0] PH_WBIT   = 4'd2;
  localparam logic [3:0] PH_WACK   = 4'd3;
  localparam logic [3:0] PH_GAP    = 4'd4;
  localparam logic [3:0] PH_RPRE   = 4'd5;
  localparam logic [3:0] PH_RBIT   = 4'd6;
  localparam logic [3:0] PH_RACK   = 4'd7;
  localparam logic [3:0] PH_STOP   = 4'd8;
  localparam logic [3:0] PH_REC    = 4'd9;
  localparam logic [3:0] PH_RECEND = 4'd10;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NAK     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REC_ERR = 2'd2;

  // configuration
  logic [BYTE_W-1:0] wr_addr_r, rd_addr_r;
  logic [ATT_W-1:0]  max_att_r;
  logic [RCLK_W-1:0] rec_clk_r;

  // sequencer state
  logic [3:0]        phase_r, phase_nxt;
  logic [2:0]        sub_r, sub_nxt;
  logic [3:0]        bit_cnt_r, bit_cnt_nxt;
  logic [LEN_W-1:0]  byte_cnt_r, byte_cnt_nxt;
  logic [ATT_W-1:0]  att_cnt_r, att_cnt_nxt;
  logic [BYTE_W-1:0] shift_r, shift_nxt;
  logic              nak_r, nak_nxt;
  logic [RCLK_W-1:0] rec_cnt_r, rec_cnt_nxt;
  logic              is_read_r, is_read_nxt;
  logic [LEN_W-1:0]  xfer_len_r, xfer_len_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_latch_r, sda_latch_nxt;
  logic              sda_float_r, sda_float_nxt;

  logic [BYTE_W-1:0] payload_r [PAYLOAD_DEPTH];
  logic              pl_we;

  // result buffer
  i2cm_res_t res;
  i2cm_res_t out_r, skid_r;
  logic      out_valid_r, skid_valid_r;

  logic              acc, take;
  logic [LEN_W-1:0]  len_c;
  logic [3:0]        bit_inc;
  logic [LEN_W:0]    byte_inc;
  logic [ATT_W-1:0]  att_lim;
  logic [RCLK_W-1:0] rec_lim;
  logic              last_byte;

  assign in_ch.ready  = !skid_valid_r;
  assign cfg_ch.ready = 1'b1;
  assign acc  = in_ch.valid && in_ch.ready;
  assign take = out_valid_r && out_ch.ready;

  assign bit_inc   = bit_cnt_r + 4'd1;
  assign byte_inc  = {1'b0, byte_cnt_r} + {{LEN_W{1'b0}}, 1'b1};
  assign att_lim   = (max_att_r == '0) ? ATT_W'(1) : max_att_r;
  assign rec_lim   = (rec_clk_r == '0) ? RCLK_W'(1) : rec_clk_r;
  assign last_byte = byte_inc >= {1'b0, xfer_len_r};

  always_comb begin
    phase_nxt     = phase_r;
    sub_nxt       = sub_r;
    bit_cnt_nxt   = bit_cnt_r;
    byte_cnt_nxt  = byte_cnt_r;
    att_cnt_nxt   = att_cnt_r;
    shift_nxt     = shift_r;
    nak_nxt       = nak_r;
    rec_cnt_nxt   = rec_cnt_r;
    is_read_nxt   = is_read_r;
    xfer_len_nxt  = xfer_len_r;
    scl_nxt       = scl_r;
    sda_latch_nxt = sda_latch_r;
    sda_float_nxt = sda_float_r;
    pl_we         = 1'b0;
    len_c         = in_ch.length;
    res           = '0;

    priority if (in_ch.func == FN_LOAD) begin
      pl_we = int'(in_ch.byte_index) < PAYLOAD_DEPTH;
    end else if (in_ch.func == FN_WRITE || in_ch.func == FN_READ) begin
      if (phase_r == PH_IDLE) begin
        is_read_nxt = in_ch.func == FN_READ;
        if (!is_read_nxt && int'(in_ch.length) > PAYLOAD_DEPTH) begin
          len_c = LEN_W'(PAYLOAD_DEPTH);
        end
        xfer_len_nxt = len_c;
        att_cnt_nxt  = ATT_W'(1);
        phase_nxt    = PH_START;
        sub_nxt      = '0;
        bit_cnt_nxt  = '0;
        byte_cnt_nxt = '0;
        nak_nxt      = 1'b0;
      end
    end else if (in_ch.func == FN_REC) begin
      if (phase_r == PH_IDLE) begin
        phase_nxt   = PH_REC;
        sub_nxt     = '0;
        rec_cnt_nxt = '0;
      end
    end else if (in_ch.func == FN_TICK) begin
      unique case (phase_r)
        PH_START: begin
          if (sub_r == 3'd0) begin
            scl_nxt = 1'b1; sda_latch_nxt = 1'b1; sda_float_nxt = 1'b0; sub_nxt = 3'd1;
          end else if (sub_r == 3'd1) begin
            sda_latch_nxt = 1'b0; sda_float_nxt = 1'b0; sub_nxt = 3'd2;
          end else begin
            scl_nxt     = 1'b0;
            shift_nxt   = is_read_r ? rd_addr_r : wr_addr_r;
            bit_cnt_nxt = '0;
            phase_nxt   = PH_WBIT;
            sub_nxt     = '0;
          end
        end
        PH_WBIT: begin
          if (sub_r == 3'd0) begin
            scl_nxt = 1'b0; sub_nxt = 3'd1;
          end else if (sub_r == 3'd1) begin
            sda_latch_nxt = shift_r[BYTE_W-1]; sda_float_nxt = 1'b0; sub_nxt = 3'd2;
          end else begin
            scl_nxt     = 1'b1;
            shift_nxt   = {shift_r[BYTE_W-2:0], 1'b0};
            bit_cnt_nxt = bit_inc;
            sub_nxt     = '0;
            if (bit_inc >= 4'd8) begin
              bit_cnt_nxt = '0;
              phase_nxt   = PH_WACK;
            end
          end
        end
        PH_WACK: begin
          if (sub_r == 3'd0) begin
            scl_nxt = 1'b0; sub_nxt = 3'd1;
          end else if (sub_r == 3'd1) begin
            sda_float_nxt = 1'b1; sub_nxt = 3'd2;
          end else if (sub_r == 3'd2) begin
            scl_nxt = 1'b1;
            if (!is_read_r && in_ch.sda_in) nak_nxt = 1'b1;
            sub_nxt = 3'd3;
          end else if (sub_r == 3'd3) begin
            sub_nxt = 3'd4;
          end else begin
            scl_nxt       = 1'b0;
            sda_float_nxt = 1'b0;
            sub_nxt       = '0;
            phase_nxt = (is_read_r || byte_cnt_r < xfer_len_r) ? PH_GAP : PH_STOP;
          end
        end
        PH_GAP: begin
          sub_nxt = '0;
          if (is_read_r) begin
            phase_nxt = (xfer_len_r == '0) ? PH_STOP : PH_RPRE;
          end else begin
            shift_nxt = (int'(byte_cnt_r) < PAYLOAD_DEPTH) ?
                        payload_r[PL_AW'(byte_cnt_r)] : '0;
            byte_cnt_nxt = byte_inc[LEN_W-1:0];
            bit_cnt_nxt  = '0;
            phase_nxt    = PH_WBIT;
          end
        end
        PH_RPRE: begin
          scl_nxt       = 1'b0;
          sda_float_nxt = 1'b1;
          shift_nxt     = '0;
          bit_cnt_nxt   = '0;
          sub_nxt       = '0;
          phase_nxt     = PH_RBIT;
        end
        PH_RBIT: begin
          if (sub_r == 3'd0) begin
            scl_nxt = 1'b0; sub_nxt = 3'd1;
          end else if (sub_r == 3'd1) begin
            scl_nxt = 1'b1; sub_nxt = 3'd2;
          end else begin
            shift_nxt   = {shift_r[BYTE_W-2:0], in_ch.sda_in};
            bit_cnt_nxt = bit_inc;
            sub_nxt     = '0;
            if (bit_inc >= 4'd8) begin
              bit_cnt_nxt    = '0;
              res.read_data  = shift_nxt;
              res.read_valid = 1'b1;
              res.read_last  = last_byte;
              phase_nxt      = PH_RACK;
            end
          end
        end
        PH_RACK: begin
          if (sub_r == 3'd0) begin
            scl_nxt = 1'b0; sub_nxt = 3'd1;
          end else if (sub_r == 3'd1) begin
            sda_float_nxt = 1'b0; sub_nxt = 3'd2;
          end else if (sub_r == 3'd2) begin
            // ack all bytes but the last, nak the last
            sda_latch_nxt = last_byte; sda_float_nxt = 1'b0; sub_nxt = 3'd3;
          end else begin
            scl_nxt      = 1'b1;
            byte_cnt_nxt = byte_inc[LEN_W-1:0];
            sub_nxt      = '0;
            phase_nxt    = (byte_inc < {1'b0, xfer_len_r}) ? PH_RPRE : PH_STOP;
          end
        end
        PH_STOP: begin
          if (sub_r == 3'd0) begin
            scl_nxt = 1'b0; sda_latch_nxt = 1'b0; sda_float_nxt = 1'b0; sub_nxt = 3'd1;
          end else if (sub_r == 3'd1) begin
            scl_nxt = 1'b1; sub_nxt = 3'd2;
          end else begin
            sda_latch_nxt = 1'b1;
            sda_float_nxt = 1'b0;
            sub_nxt       = '0;
            if (!is_read_r && nak_r && att_cnt_r < att_lim) begin
              // resend the whole frame
              att_cnt_nxt  = att_cnt_r + ATT_W'(1);
              phase_nxt    = PH_START;
              bit_cnt_nxt  = '0;
              byte_cnt_nxt = '0;
              nak_nxt      = 1'b0;
            end else begin
              res.done_res = 1'b1;
              res.status   = (!is_read_r && nak_r) ? ST_NAK : ST_OK;
              phase_nxt    = PH_IDLE;
            end
          end
        end
        PH_REC: begin
          if (sub_r == 3'd0) begin
            scl_nxt       = 1'b1;
            sda_float_nxt = 1'b1;
            if (in_ch.sda_in) begin
              sda_latch_nxt = 1'b1;
              sda_float_nxt = 1'b0;
              phase_nxt     = PH_RECEND;
              sub_nxt       = '0;
            end else begin
              sub_nxt = 3'd1;
            end
          end else if (sub_r == 3'd1) begin
            scl_nxt = 1'b0; sub_nxt = 3'd2;
          end else begin
            scl_nxt     = 1'b1;
            rec_cnt_nxt = rec_cnt_r + RCLK_W'(1);
            sub_nxt     = '0;
            if (rec_cnt_nxt >= rec_lim) begin
              res.done_res = 1'b1;
              res.status   = ST_REC_ERR;
              phase_nxt    = PH_IDLE;
            end
          end
        end
        PH_RECEND: begin
          if (sub_r == 3'd0) begin
            scl_nxt = 1'b0; sub_nxt = 3'd1;
          end else begin
            scl_nxt       = 1'b1;
            sda_latch_nxt = 1'b1;
            sda_float_nxt = 1'b0;
            sub_nxt       = '0;
            res.done_res  = 1'b1;
            phase_nxt     = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end else begin
      // unused command codes are ignored
    end

    res.scl_level   = scl_nxt;
    res.sda_release = sda_float_nxt | sda_latch_nxt;
    res.busy_res    = phase_nxt != PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_addr_r <= WR_ADDR_RST;
      rd_addr_r <= RD_ADDR_RST;
      max_att_r <= MAX_ATT_RST;
      rec_clk_r <= REC_CLK_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_WR_ADDR: wr_addr_r <= cfg_ch.data;
        CFG_RD_ADDR: rd_addr_r <= cfg_ch.data;
        CFG_MAX_ATT: max_att_r <= cfg_ch.data[ATT_W-1:0];
        CFG_REC_CLK: rec_clk_r <= cfg_ch.data[RCLK_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      sub_r       <= '0;
      bit_cnt_r   <= '0;
      byte_cnt_r  <= '0;
      att_cnt_r   <= '0;
      shift_r     <= '0;
      nak_r       <= 1'b0;
      rec_cnt_r   <= '0;
      is_read_r   <= 1'b0;
      xfer_len_r  <= '0;
      scl_r       <= 1'b1;
      sda_latch_r <= 1'b1;
      sda_float_r <= 1'b0;
    end else if (acc) begin
      phase_r     <= phase_nxt;
      sub_r       <= sub_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      att_cnt_r   <= att_cnt_nxt;
      shift_r     <= shift_nxt;
      nak_r       <= nak_nxt;
      rec_cnt_r   <= rec_cnt_nxt;
      is_read_r   <= is_read_nxt;
      xfer_len_r  <= xfer_len_nxt;
      scl_r       <= scl_nxt;
      sda_latch_r <= sda_latch_nxt;
      sda_float_r <= sda_float_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && pl_we) begin
      payload_r[PL_AW'(in_ch.byte_index)] <= in_ch.byte_value;
    end
  end

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (acc) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) out_r <= skid_r;
    end else if (acc) begin
      if (!out_valid_r || take) out_r <= res;
      else skid_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.scl_level   = out_r.scl_level;
  assign out_ch.sda_release = out_r.sda_release;
  assign out_ch.read_data   = out_r.read_data;
  assign out_ch.read_valid  = out_r.read_valid;
  assign out_ch.read_last   = out_r.read_last;
  assign out_ch.done_res    = out_r.done_res;
  assign out_ch.status      = out_r.status;
  assign out_ch.busy_res    = out_r.busy_res;

endmodule

/* rtl/i2cm_checker.sv */
// i2cm_checker: port-level assertions for i2c_master_bitbang_engine,
// attached by the bind at the end of this file. Depends on i2cm_pkg.
module i2cm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_done,
  input logic                          out_busy,
  input logic [i2cm_pkg::STATUS_W-1:0] out_status
);
  import i2cm_pkg::*;

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // input back-pressure only when a result is waiting
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result buffer");

  // the buffer fills only from a stalled output
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready && in_valid))
    else $error("input ready dropped without output stall");

  // a finished transaction leaves the block idle, status only on done
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_done || out_status != '0) |-> out_done && !out_busy)
    else $error("done/status inconsistent with busy");

endmodule

bind i2c_master_bitbang_engine i2cm_checker u_i2cm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_done   (out_ch.done_res),
  .out_busy   (out_ch.busy_res),
  .out_status (out_ch.status)
);

/* sim/i2c_master_bitbang_engine_tb.sv */
// i2c_master_bitbang_engine_tb: self-checking bench for the tick-driven I2C master.
// Drives command words with random gaps and output stalls, and predicts every result
// word bit for bit. Depends on rtl/i2cm_pkg.sv, rtl/i2cm_if.sv and the engine.
`timescale 1ns / 100ps

module i2c_master_bitbang_engine_tb;
  import i2cm_pkg::*;

  typedef enum logic [FUNC_W-1:0] {
    F_TICK = 3'd0, F_LOAD = 3'd1, F_WRITE = 3'd2, F_READ = 3'd3, F_RECOVER = 3'd4
  } func_e;
  localparam logic [FUNC_W-1:0] F_UNUSED_LO = F_RECOVER + 1'b1;
  localparam logic [FUNC_W-1:0] F_UNUSED_HI = {FUNC_W{1'b1}};

  typedef enum logic [STATUS_W-1:0] {ST_OK, ST_NAK, ST_REC_FAIL} status_e;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WR_ADDR, REG_RD_ADDR, REG_MAX_ATT, REG_REC_CLKS
  } reg_e;
  typedef enum logic [4:0] {
    PH_IDLE, PH_START, PH_WBIT, PH_WACK, PH_GAP, PH_RPRE, PH_RBIT, PH_RACK,
    PH_STOP, PH_REC, PH_RECEND
  } bus_phase_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              sda_in;
    logic [BYTE_W-1:0] byte_value;
    logic [BIDX_W-1:0] byte_index;
    logic [LEN_W-1:0]  length;
  } cmd_t;

  class bus_word_scoreboard;
    logic [BYTE_W-1:0] wr_addr, rd_addr;
    logic [ATT_W-1:0]  max_att, att_cnt;
    logic [RCLK_W-1:0] rec_clks, rec_cnt;
    bus_phase_e        phase;
    logic [2:0]        sub_step;
    logic [3:0]        bit_cnt, byte_cnt;
    logic [LEN_W-1:0]  xfer_len;
    logic [BYTE_W-1:0] shreg;
    logic [BYTE_W-1:0] payload [PAYLOAD_DEPTH];
    logic              nak_seen, is_rd, scl, sda_lat, sda_flt;
    i2cm_res_t         pending_results [$];
    int                errors;
    int                checked;

    function new();
      wr_addr = WR_ADDR_RST;
      rd_addr = RD_ADDR_RST;
      max_att = MAX_ATT_RST;
      rec_clks = REC_CLK_RST;
      phase = PH_IDLE;
      sub_step = '0;
      bit_cnt = '0;
      byte_cnt = '0;
      att_cnt = '0;
      shreg = '0;
      nak_seen = 1'b0;
      rec_cnt = '0;
      is_rd = 1'b0;
      xfer_len = '0;
      scl = 1'b1;
      sda_lat = 1'b1;
      sda_flt = 1'b0;
      errors = 0;
      checked = 0;
      foreach (payload[i]) payload[i] = '0;
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void set_reg(reg_e idx, logic [BYTE_W-1:0] data);
      case (idx)
        REG_WR_ADDR:  wr_addr = data;
        REG_RD_ADDR:  rd_addr = data;
        REG_MAX_ATT:  max_att = data[ATT_W-1:0];
        REG_REC_CLKS: rec_clks = data[RCLK_W-1:0];
        default: ;
      endcase
    endfunction

    function void new_frame();
      phase = PH_START;
      sub_step = '0;
      bit_cnt = '0;
      byte_cnt = '0;
      nak_seen = 1'b0;
    endfunction

    // one accepted command word -> one expected result word
    function void take_command(cmd_t c);
      i2cm_res_t r;
      int lim;
      bit last_byte;
      r = '0;
      last_byte = (int'(byte_cnt) + 1 >= int'(xfer_len));
      case (c.func)
        F_LOAD: payload[c.byte_index] = c.byte_value;
        F_WRITE, F_READ: begin
          if (phase == PH_IDLE) begin
            is_rd = (c.func == F_READ);
            xfer_len = (!is_rd && c.length > PAYLOAD_DEPTH) ? LEN_W'(PAYLOAD_DEPTH) : c.length;
            att_cnt = 1;
            new_frame();
          end
        end
        F_RECOVER: begin
          if (phase == PH_IDLE) begin
            phase = PH_REC;
            sub_step = '0;
            rec_cnt = '0;
          end
        end
        F_TICK: begin
          case (phase)
            PH_START: begin
              if (sub_step == 0) begin
                scl = 1'b1; sda_lat = 1'b1; sda_flt = 1'b0; sub_step = 1;
              end else if (sub_step == 1) begin
                sda_lat = 1'b0; sda_flt = 1'b0; sub_step = 2;
              end else begin
                scl = 1'b0;
                shreg = is_rd ? rd_addr : wr_addr;
                bit_cnt = '0;
                phase = PH_WBIT;
                sub_step = '0;
              end
            end
            PH_WBIT: begin
              if (sub_step == 0) begin
                scl = 1'b0; sub_step = 1;
              end else if (sub_step == 1) begin
                sda_lat = shreg[7]; sda_flt = 1'b0; sub_step = 2;
              end else begin
                scl = 1'b1;
                shreg = shreg << 1;
                bit_cnt++;
                sub_step = '0;
                if (bit_cnt >= 8) begin
                  bit_cnt = '0;
                  phase = PH_WACK;
                end
              end
            end
            PH_WACK: begin
              if (sub_step == 0) begin
                scl = 1'b0; sub_step = 1;
              end else if (sub_step == 1) begin
                sda_flt = 1'b1; sub_step = 2;
              end else if (sub_step == 2) begin
                scl = 1'b1;
                if (!is_rd && c.sda_in) nak_seen = 1'b1;
                sub_step = 3;
              end else if (sub_step == 3) begin
                sub_step = 4;
              end else begin
                scl = 1'b0;
                sda_flt = 1'b0;
                sub_step = '0;
                phase = (is_rd || byte_cnt < xfer_len) ? PH_GAP : PH_STOP;
              end
            end
            PH_GAP: begin
              sub_step = '0;
              if (is_rd) begin
                phase = (xfer_len == 0) ? PH_STOP : PH_RPRE;
              end else begin
                shreg = (byte_cnt < PAYLOAD_DEPTH) ? payload[byte_cnt[BIDX_W-1:0]] : '0;
                byte_cnt++;
                bit_cnt = '0;
                phase = PH_WBIT;
              end
            end
            PH_RPRE: begin
              scl = 1'b0;
              sda_flt = 1'b1;
              shreg = '0;
              bit_cnt = '0;
              sub_step = '0;
              phase = PH_RBIT;
            end
            PH_RBIT: begin
              if (sub_step == 0) begin
                scl = 1'b0; sub_step = 1;
              end else if (sub_step == 1) begin
                scl = 1'b1; sub_step = 2;
              end else begin
                shreg = {shreg[6:0], c.sda_in};
                bit_cnt++;
                sub_step = '0;
                if (bit_cnt >= 8) begin
                  bit_cnt = '0;
                  r.read_data = shreg;
                  r.read_valid = 1'b1;
                  r.read_last = last_byte;
                  phase = PH_RACK;
                end
              end
            end
            PH_RACK: begin
              if (sub_step == 0) begin
                scl = 1'b0; sub_step = 1;
              end else if (sub_step == 1) begin
                sda_flt = 1'b0; sub_step = 2;
              end else if (sub_step == 2) begin
                // nak only on the last byte of the read
                sda_lat = last_byte; sda_flt = 1'b0; sub_step = 3;
              end else begin
                scl = 1'b1;
                byte_cnt++;
                sub_step = '0;
                phase = (byte_cnt < xfer_len) ? PH_RPRE : PH_STOP;
              end
            end
            PH_STOP: begin
              if (sub_step == 0) begin
                scl = 1'b0; sda_lat = 1'b0; sda_flt = 1'b0; sub_step = 1;
              end else if (sub_step == 1) begin
                scl = 1'b1; sub_step = 2;
              end else begin
                sda_lat = 1'b1;
                sda_flt = 1'b0;
                sub_step = '0;
                lim = (max_att != 0) ? int'(max_att) : 1;
                if (!is_rd && nak_seen && int'(att_cnt) < lim) begin
                  att_cnt++;
                  new_frame();
                end else begin
                  r.done_res = 1'b1;
                  r.status = (!is_rd && nak_seen) ? ST_NAK : ST_OK;
                  phase = PH_IDLE;
                end
              end
            end
            PH_REC: begin
              if (sub_step == 0) begin
                scl = 1'b1;
                sda_flt = 1'b1;
                if (c.sda_in) begin
                  sda_lat = 1'b1;
                  sda_flt = 1'b0;
                  phase = PH_RECEND;
                  sub_step = '0;
                end else begin
                  sub_step = 1;
                end
              end else if (sub_step == 1) begin
                scl = 1'b0; sub_step = 2;
              end else begin
                scl = 1'b1;
                rec_cnt++;
                sub_step = '0;
                lim = (rec_clks != 0) ? int'(rec_clks) : 1;
                if (int'(rec_cnt) >= lim) begin
                  r.done_res = 1'b1;
                  r.status = ST_REC_FAIL;
                  phase = PH_IDLE;
                end
              end
            end
            PH_RECEND: begin
              if (sub_step == 0) begin
                scl = 1'b0; sub_step = 1;
              end else begin
                scl = 1'b1;
                sda_lat = 1'b1;
                sda_flt = 1'b0;
                sub_step = '0;
                r.done_res = 1'b1;
                phase = PH_IDLE;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      r.scl_level = scl;
      r.sda_release = sda_flt | sda_lat;
      r.busy_res = (phase != PH_IDLE);
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task match_result(i2cm_res_t got);
      i2cm_res_t want;
      string diffs;
      if (pending_results.size() == 0) begin
        report($sformatf("result word %h with nothing expected", got));
        return;
      end
      want = pending_results.pop_front();
      diffs = "";
      if (got.scl_level !== want.scl_level) diffs = {diffs, " scl_level"};
      if (got.sda_release !== want.sda_release) diffs = {diffs, " sda_release"};
      if (got.read_data !== want.read_data) diffs = {diffs, " read_data"};
      if (got.read_valid !== want.read_valid) diffs = {diffs, " read_valid"};
      if (got.read_last !== want.read_last) diffs = {diffs, " read_last"};
      if (got.done_res !== want.done_res) diffs = {diffs, " done_res"};
      if (got.status !== want.status) diffs = {diffs, " status"};
      if (got.busy_res !== want.busy_res) diffs = {diffs, " busy_res"};
      if (diffs != "")
        report($sformatf("word %0d differs in%s: got %h want %h", checked, diffs, got, want));
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   idling = 1'b1;
  int   words_done = 0;

  i2cm_in_if  in_ch ();
  i2cm_out_if out_ch ();
  i2cm_cfg_if cfg_ch ();

  bus_word_scoreboard sb = new();

  i2c_master_bitbang_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin : result_mon
    i2cm_res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{scl_level: out_ch.scl_level, sda_release: out_ch.sda_release,
              read_data: out_ch.read_data, read_valid: out_ch.read_valid,
              read_last: out_ch.read_last, done_res: out_ch.done_res,
              status: out_ch.status, busy_res: out_ch.busy_res};
      sb.match_result(got);
    end
  end

  // receiver stalls in short bursts
  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (idling && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  function automatic cmd_t random_word(logic [FUNC_W-1:0] f);
    cmd_t w;
    w.func = f;
    w.sda_in = 1'($urandom);
    w.byte_value = BYTE_W'($urandom);
    w.byte_index = BIDX_W'($urandom);
    w.length = LEN_W'($urandom);
    return w;
  endfunction

  function automatic cmd_t noise_word();
    case ($urandom_range(0, 3))
      0: return random_word(F_TICK);
      1: return random_word(F_LOAD);
      default: return random_word(FUNC_W'($urandom_range(F_UNUSED_LO, F_UNUSED_HI)));
    endcase
  endfunction

  // returns just after the accepting edge; the predictor is already updated
  task automatic send_word(input cmd_t c);
    bit counted;
    counted = (c.func == F_LOAD) || (c.func == F_TICK && sb.busy()) ||
              ((c.func inside {F_WRITE, F_READ, F_RECOVER}) && !sb.busy());
    @(negedge clk);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= c.func;
    in_ch.sda_in <= c.sda_in;
    in_ch.byte_value <= c.byte_value;
    in_ch.byte_index <= c.byte_index;
    in_ch.length <= c.length;
    do @(posedge clk); while (!in_ch.ready);
    sb.take_command(c);
    if (counted) words_done++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic load_regs(input logic [BYTE_W-1:0] wa, ra, ma, rc);
    logic [BYTE_W-1:0] vals [4];
    vals = '{wa, ra, ma, rc};
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= reg_e'(i);
      cfg_ch.data <= vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
      sb.set_reg(reg_e'(i), vals[i]);
      @(negedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // fault_pct: chance of a nak on each write ack, or of sda held low on each
  // recovery sample; meddle mixes in loads, starts and junk while busy
  task automatic run_txn(input func_e kind, input int len, input int fault_pct,
                         input bit meddle);
    cmd_t w;
    w = random_word(kind);
    w.length = LEN_W'(len);
    send_word(w);
    while (sb.busy()) begin
      w = random_word(F_TICK);
      if (sb.phase == PH_WACK && sb.sub_step == 2)
        w.sda_in = ($urandom_range(0, 99) < fault_pct);
      else if (sb.phase == PH_REC && sb.sub_step == 0)
        w.sda_in = ($urandom_range(0, 99) >= fault_pct);
      if (meddle && $urandom_range(0, 11) == 0) begin
        case ($urandom_range(0, 2))
          0: w.func = F_LOAD;
          1: w.func = FUNC_W'($urandom_range(F_WRITE, F_RECOVER));
          default: w.func = FUNC_W'($urandom_range(F_UNUSED_LO, F_UNUSED_HI));
        endcase
      end
      send_word(w);
    end
  endtask

  task automatic random_traffic(input int amount);
    int stop;
    int pick;
    int len;
    int fault;
    stop = words_done + amount;
    while (words_done < stop) begin
      pick = $urandom_range(0, 19);
      len = (pick < 12) ? $urandom_range(0, 2) :
            (pick < 19) ? $urandom_range(3, 8) : $urandom_range(9, 15);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 3))
          0, 1: fault = 0;
          2: fault = 20;
          default: fault = 100;
        endcase
        run_txn(F_WRITE, len, fault, $urandom_range(0, 3) == 0);
      end else if (pick < 75) begin
        run_txn(F_READ, len, 0, $urandom_range(0, 3) == 0);
      end else if (pick < 87) begin
        case ($urandom_range(0, 2))
          0: fault = 30;
          1: fault = 80;
          default: fault = 100;
        endcase
        run_txn(F_RECOVER, 0, fault, $urandom_range(0, 3) == 0);
      end else begin
        repeat ($urandom_range(1, 4)) send_word(noise_word());
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] seed_bytes [PAYLOAD_DEPTH];
    cmd_t w;
    seed_bytes = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F, 8'hFE};
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = F_TICK;
    in_ch.sda_in = 1'b1;
    in_ch.byte_value = '0;
    in_ch.byte_index = '0;
    in_ch.length = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_WR_ADDR;
    cfg_ch.data = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // every slot loaded before any write can send it
    for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
      w = random_word(F_LOAD);
      w.byte_index = BIDX_W'(i);
      w.byte_value = seed_bytes[i];
      send_word(w);
    end
    send_word(random_word(F_TICK));
    for (int f = F_UNUSED_LO; f <= F_UNUSED_HI; f++) send_word(random_word(FUNC_W'(f)));
    run_txn(F_WRITE, 0, 100, 1'b0);
    run_txn(F_WRITE, 15, 0, 1'b1);
    run_txn(F_READ, 0, 0, 1'b0);
    run_txn(F_READ, 9, 0, 1'b1);
    run_txn(F_RECOVER, 0, 0, 1'b0);
    run_txn(F_RECOVER, 0, 100, 1'b0);

    load_regs(8'h00, 8'hFF, 8'd7, 8'd15);
    random_traffic(20);
    load_regs(8'hFF, 8'h00, 8'd1, 8'd1);
    random_traffic(20);
    // zero limits behave as one
    load_regs(BYTE_W'($urandom), BYTE_W'($urandom), 8'd0, 8'd0);
    random_traffic(20);
    load_regs(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom_range(1, 7)),
              BYTE_W'($urandom_range(1, 15)));
    idling = 1'b0;
    random_traffic(20);

    wait_drained();
    repeat (4) @(negedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/i2cm_pkg.sv
rtl/i2cm_if.sv
rtl/i2c_master_bitbang_engine.sv
rtl/i2cm_checker.sv
sim/i2c_master_bitbang_engine_tb.sv
